// File: rtl/core/pwmaf_pkg.sv
// ----------------------------------------------------------------------------
// pwmaf_pkg
// Shared types, widths and decode helpers for the PWM audio FIFO timer.
// ----------------------------------------------------------------------------
package pwmaf_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int CYCLE_W        = 32;
    localparam int PERIOD_W       = 12;
    localparam int MODE_W         = 4;
    localparam int IRQ_SET_W      = 4;
    localparam int COUNT_W        = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [COUNT_W-1:0] IRQ_RELOAD_MAX = COUNT_W'(16);

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_PUSH_LEFT  = 2'd1,
        OP_PUSH_RIGHT = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUTING_MODE      = 3'd0,
        CFG_SOUND_ENABLE      = 3'd1,
        CFG_CYCLE_SETTING     = 3'd2,
        CFG_INTERRUPT_SETTING = 3'd3,
        CFG_MASTER_IRQ_ENABLE = 3'd4,
        CFG_SLAVE_IRQ_ENABLE  = 3'd5
    } cfg_idx_t;

    // Which FIFO pops and where its sample lands.
    typedef struct packed {
        logic l_pop;
        logic l_to_right;
        logic r_pop;
        logic r_to_right;
    } route_t;

    // Memory strobes from the control unit.
    typedef struct packed {
        logic l_wr;
        logic l_rd;
        logic r_wr;
        logic r_rd;
    } fifo_en_t;

    // Per-request result info carried to the level/output stage.
    typedef struct packed {
        route_t route;
        logic   fired;
        logic   irq_m;
        logic   irq_s;
        logic   l_full;
        logic   r_full;
        logic   dropped;
    } item_info_t;

    function automatic route_t route_decode(input logic [MODE_W-1:0] mode);
        route_t r;
        r = '0;
        unique case (mode) inside
            4'h1, 4'hD: r.l_pop = 1'b1;
            4'h2, 4'hE:
            begin
                r.l_pop      = 1'b1;
                r.l_to_right = 1'b1;
            end
            4'h4, 4'h7: r.r_pop = 1'b1;
            4'h5, 4'h9:
            begin
                r.l_pop      = 1'b1;
                r.r_pop      = 1'b1;
                r.r_to_right = 1'b1;
            end
            4'h6, 4'hA:
            begin
                r.l_pop      = 1'b1;
                r.l_to_right = 1'b1;
                r.r_pop      = 1'b1;
            end
            4'h8, 4'hB:
            begin
                r.r_pop      = 1'b1;
                r.r_to_right = 1'b1;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] irq_reload(input logic [IRQ_SET_W-1:0] setting);
        return (setting == '0) ? IRQ_RELOAD_MAX : COUNT_W'(setting);
    endfunction

endpackage

// File: rtl/core/pwmaf_fifo_mem.sv
// ----------------------------------------------------------------------------
// pwmaf_fifo_mem
// Sample store for one channel: one write port, one read port, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module pwmaf_fifo_mem #(
    parameter int FIFO_DEPTH = pwmaf_pkg::FIFO_DEPTH_DEF,
    parameter int PTR_W      = $clog2(FIFO_DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [PTR_W-1:0]              wr_addr,
    input  logic [pwmaf_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [PTR_W-1:0]              rd_addr,
    output logic [pwmaf_pkg::SAMPLE_W-1:0] rd_data
);

    logic [pwmaf_pkg::SAMPLE_W-1:0] mem [FIFO_DEPTH];
    logic [pwmaf_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/pwmaf_ctrl.sv
// ----------------------------------------------------------------------------
// pwmaf_ctrl
// Configuration registers, FIFO pointers, period timer and interrupt divider.
// Decides pushes, pops and interrupts for each accepted request.
// ----------------------------------------------------------------------------
module pwmaf_ctrl #(
    parameter int FIFO_DEPTH = pwmaf_pkg::FIFO_DEPTH_DEF,
    parameter int PTR_W      = $clog2(FIFO_DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pwmaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pwmaf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            accept,
    input  logic [1:0]                      operation,
    input  logic [pwmaf_pkg::CYCLE_W-1:0]   cycle_now,
    output pwmaf_pkg::fifo_en_t             fifo_en,
    output logic [PTR_W-1:0]                l_wr_ptr,
    output logic [PTR_W-1:0]                l_rd_ptr,
    output logic [PTR_W-1:0]                r_wr_ptr,
    output logic [PTR_W-1:0]                r_rd_ptr,
    output pwmaf_pkg::item_info_t           info
);

    logic [pwmaf_pkg::MODE_W-1:0]    mode_reg;
    logic                            snd_en_reg;
    logic [pwmaf_pkg::PERIOD_W-1:0]  cyc_set_reg;
    logic [pwmaf_pkg::IRQ_SET_W-1:0] irq_set_reg;
    logic                            m_irq_en_reg;
    logic                            s_irq_en_reg;

    logic [PTR_W-1:0]                l_rd_reg, l_rd_next;
    logic [PTR_W-1:0]                l_wr_reg, l_wr_next;
    logic [PTR_W-1:0]                r_rd_reg, r_rd_next;
    logic [PTR_W-1:0]                r_wr_reg, r_wr_next;
    logic [pwmaf_pkg::CYCLE_W-1:0]   target_reg, target_next;
    logic [pwmaf_pkg::COUNT_W-1:0]   count_reg, count_next;

    logic [pwmaf_pkg::PERIOD_W-1:0]  period;
    logic [pwmaf_pkg::COUNT_W-1:0]   count_dec;
    pwmaf_pkg::op_t                  op;
    pwmaf_pkg::route_t               route;
    logic                            fire;
    logic                            l_pop, r_pop;
    logic                            l_push, r_push;
    logic                            l_full_now, r_full_now;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign op     = pwmaf_pkg::op_t'(operation);
    assign period = cyc_set_reg - 1'b1;
    assign route  = pwmaf_pkg::route_decode(mode_reg);

    assign l_full_now = (next_slot(l_wr_reg) == l_rd_reg);
    assign r_full_now = (next_slot(r_wr_reg) == r_rd_reg);

    assign fire = (op == pwmaf_pkg::OP_TICK) && (snd_en_reg || (mode_reg != '0))
                  && (period != '0) && (target_reg <= cycle_now);

    assign l_pop  = fire && route.l_pop && (l_rd_reg != l_wr_reg);
    assign r_pop  = fire && route.r_pop && (r_rd_reg != r_wr_reg);
    assign l_push = (op == pwmaf_pkg::OP_PUSH_LEFT) && !l_full_now;
    assign r_push = (op == pwmaf_pkg::OP_PUSH_RIGHT) && !r_full_now;

    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        l_rd_next   = l_pop ? next_slot(l_rd_reg) : l_rd_reg;
        r_rd_next   = r_pop ? next_slot(r_rd_reg) : r_rd_reg;
        l_wr_next   = l_push ? next_slot(l_wr_reg) : l_wr_reg;
        r_wr_next   = r_push ? next_slot(r_wr_reg) : r_wr_reg;
        target_next = target_reg;
        count_next  = count_reg;

        info                  = '0;
        info.route.l_pop      = l_pop;
        info.route.l_to_right = route.l_to_right;
        info.route.r_pop      = r_pop;
        info.route.r_to_right = route.r_to_right;
        info.fired            = fire;

        if (fire)
        begin
            target_next = target_reg + pwmaf_pkg::CYCLE_W'(period);
            if (count_dec == '0)
            begin
                count_next = pwmaf_pkg::irq_reload(irq_set_reg);
                info.irq_m = m_irq_en_reg;
                info.irq_s = s_irq_en_reg;
            end
            else
            begin
                count_next = count_dec;
            end
        end
        if (op == pwmaf_pkg::OP_CLEAR)
        begin
            target_next = '0;
        end

        info.dropped = ((op == pwmaf_pkg::OP_PUSH_LEFT) && l_full_now)
                       || ((op == pwmaf_pkg::OP_PUSH_RIGHT) && r_full_now);
        info.l_full  = (next_slot(l_wr_next) == l_rd_next);
        info.r_full  = (next_slot(r_wr_next) == r_rd_next);
    end

    assign fifo_en.l_wr = accept && l_push;
    assign fifo_en.r_wr = accept && r_push;
    assign fifo_en.l_rd = accept && l_pop;
    assign fifo_en.r_rd = accept && r_pop;
    assign l_wr_ptr = l_wr_reg;
    assign l_rd_ptr = l_rd_reg;
    assign r_wr_ptr = r_wr_reg;
    assign r_rd_ptr = r_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            snd_en_reg   <= 1'b0;
            cyc_set_reg  <= '0;
            irq_set_reg  <= '0;
            m_irq_en_reg <= 1'b0;
            s_irq_en_reg <= 1'b0;
            l_rd_reg     <= '0;
            l_wr_reg     <= '0;
            r_rd_reg     <= '0;
            r_wr_reg     <= '0;
            target_reg   <= '0;
            count_reg    <= pwmaf_pkg::IRQ_RELOAD_MAX;
        end
        else
        begin
            if (accept)
            begin
                l_rd_reg   <= l_rd_next;
                l_wr_reg   <= l_wr_next;
                r_rd_reg   <= r_rd_next;
                r_wr_reg   <= r_wr_next;
                target_reg <= target_next;
                count_reg  <= count_next;
            end
            if (cfg_wr_en)
            begin
                unique case (pwmaf_pkg::cfg_idx_t'(cfg_index))
                    pwmaf_pkg::CFG_ROUTING_MODE:
                        mode_reg <= cfg_data[pwmaf_pkg::MODE_W-1:0];
                    pwmaf_pkg::CFG_SOUND_ENABLE:
                        snd_en_reg <= cfg_data[0];
                    pwmaf_pkg::CFG_CYCLE_SETTING:
                        cyc_set_reg <= cfg_data[pwmaf_pkg::PERIOD_W-1:0];
                    pwmaf_pkg::CFG_INTERRUPT_SETTING:
                    begin
                        irq_set_reg <= cfg_data[pwmaf_pkg::IRQ_SET_W-1:0];
                        count_reg   <= pwmaf_pkg::irq_reload(
                                           cfg_data[pwmaf_pkg::IRQ_SET_W-1:0]);
                    end
                    pwmaf_pkg::CFG_MASTER_IRQ_ENABLE:
                        m_irq_en_reg <= cfg_data[0];
                    pwmaf_pkg::CFG_SLAVE_IRQ_ENABLE:
                        s_irq_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (l_rd_reg <= PTR_W'(FIFO_DEPTH - 1)) && (l_wr_reg <= PTR_W'(FIFO_DEPTH - 1))
        && (r_rd_reg <= PTR_W'(FIFO_DEPTH - 1)) && (r_wr_reg <= PTR_W'(FIFO_DEPTH - 1)))
        else $error("FIFO pointer out of range");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= pwmaf_pkg::IRQ_RELOAD_MAX))
        else $error("interrupt countdown out of range");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_en.l_rd |=> (l_rd_reg != $past(l_rd_reg)))
        else $error("left pop did not advance read pointer");

endmodule

// File: rtl/core/pwm_audio_fifo_timer.sv
// ----------------------------------------------------------------------------
// pwm_audio_fifo_timer
// Two-channel PWM sound unit: per-channel sample FIFOs, period timer and
// interrupt divider, with a registered result channel.
// ----------------------------------------------------------------------------
// Flow: a request accepted into stage 1 moves on to the output register when
//   that register is free or being drained; its result is taken from there.
// Throughput: one request per cycle; the FIFO memory read and the output
//   register form a two-stage pipeline that stalls only on out_ready.
// Reset: rst_n clears configuration, pointers, timer target and levels and
//   loads the interrupt countdown with sixteen; FIFO memories are not cleared,
//   no clearing pass is needed and a request is taken on the first cycle.
module pwm_audio_fifo_timer #(
    parameter int FIFO_DEPTH = pwmaf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [pwmaf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwmaf_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [pwmaf_pkg::CYCLE_W-1:0]    cycle_now,
    input  logic [pwmaf_pkg::SAMPLE_W-1:0]   sample,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pwmaf_pkg::SAMPLE_W-1:0]   out_left,
    output logic [pwmaf_pkg::SAMPLE_W-1:0]   out_right,
    output logic                             timer_fired,
    output logic                             irq_master,
    output logic                             irq_slave,
    output logic                             left_full,
    output logic                             right_full,
    output logic                             push_dropped
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic                  accept;
    logic                  advance;
    pwmaf_pkg::fifo_en_t   fifo_en;
    pwmaf_pkg::item_info_t info;
    logic [PTR_W-1:0]      l_wr_ptr, l_rd_ptr, r_wr_ptr, r_rd_ptr;
    logic [pwmaf_pkg::SAMPLE_W-1:0] l_q, r_q;

    // Stage 1: request decided, memory read in flight.
    logic                  s1_valid_reg;
    pwmaf_pkg::item_info_t s1_info_reg;

    // Architectural output levels, updated when a request leaves stage 1.
    logic [pwmaf_pkg::SAMPLE_W-1:0] lev_l_reg, lev_l_next;
    logic [pwmaf_pkg::SAMPLE_W-1:0] lev_r_reg, lev_r_next;

    // Output register.
    logic                           out_valid_reg;
    logic [pwmaf_pkg::SAMPLE_W-1:0] out_left_reg, out_right_reg;
    pwmaf_pkg::item_info_t          out_info_reg;

    // Stage 1 moves on whenever the output register is free or being drained;
    // a new request enters whenever stage 1 is empty or empties at the same edge.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    pwmaf_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PTR_W      (PTR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .operation (operation),
        .cycle_now (cycle_now),
        .fifo_en   (fifo_en),
        .l_wr_ptr  (l_wr_ptr),
        .l_rd_ptr  (l_rd_ptr),
        .r_wr_ptr  (r_wr_ptr),
        .r_rd_ptr  (r_rd_ptr),
        .info      (info)
    );

    // Read data holds while stage 1 stalls, since reads fire only on accept.
    pwmaf_fifo_mem #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PTR_W      (PTR_W)
    ) u_left_mem (
        .clk     (clk),
        .wr_en   (fifo_en.l_wr),
        .wr_addr (l_wr_ptr),
        .wr_data (sample),
        .rd_en   (fifo_en.l_rd),
        .rd_addr (l_rd_ptr),
        .rd_data (l_q)
    );

    pwmaf_fifo_mem #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PTR_W      (PTR_W)
    ) u_right_mem (
        .clk     (clk),
        .wr_en   (fifo_en.r_wr),
        .wr_addr (r_wr_ptr),
        .wr_data (sample),
        .rd_en   (fifo_en.r_rd),
        .rd_addr (r_rd_ptr),
        .rd_data (r_q)
    );

    // Route popped samples into the levels; an empty FIFO leaves a level as is.
    always_comb
    begin
        lev_l_next = lev_l_reg;
        lev_r_next = lev_r_reg;
        if (s1_info_reg.route.l_pop)
        begin
            if (s1_info_reg.route.l_to_right)
            begin
                lev_r_next = l_q;
            end
            else
            begin
                lev_l_next = l_q;
            end
        end
        if (s1_info_reg.route.r_pop)
        begin
            if (s1_info_reg.route.r_to_right)
            begin
                lev_r_next = r_q;
            end
            else
            begin
                lev_l_next = r_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lev_l_reg     <= '0;
            lev_r_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    lev_l_reg <= lev_l_next;
                    lev_r_reg <= lev_r_next;
                end
            end
        end
    end

    // Payload registers: load stage 1 on accept, the output on advance with stage 1 valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (advance && s1_valid_reg)
        begin
            out_left_reg  <= lev_l_next;
            out_right_reg <= lev_r_next;
            out_info_reg  <= s1_info_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_left     = out_left_reg;
    assign out_right    = out_right_reg;
    assign timer_fired  = out_info_reg.fired;
    assign irq_master   = out_info_reg.irq_m;
    assign irq_slave    = out_info_reg.irq_s;
    assign left_full    = out_info_reg.l_full;
    assign right_full   = out_info_reg.r_full;
    assign push_dropped = out_info_reg.dropped;

    a_irq_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (timer_fired || (!irq_master && !irq_slave)))
        else $error("interrupt raised without timer event");

    a_fire_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timer_fired && push_dropped))
        else $error("timer event and dropped push on one request");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request taken while pipeline is full");

    a_pop_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_info_reg.route.l_pop || s1_info_reg.route.r_pop))
        |-> s1_info_reg.fired)
        else $error("FIFO pop without timer event");

endmodule
